[rtl/mdr_pkg.sv]
// Package: shared types and constants for the motor duty ramp and current sense block.
package mdr_pkg;

  // Item kinds carried in the mode field.
  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_CAL  = 2'd1,
    MODE_SET  = 2'd2,
    MODE_CLR  = 2'd3
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_RAMP_STEP   = 3'd0,
    CFG_INVERT_DIR  = 3'd1,
    CFG_FAULT_SENSE = 3'd2,
    CFG_ADC_PRESENT = 3'd3,
    CFG_ADC_PERIOD  = 3'd4,
    CFG_CUR_GAIN    = 3'd5
  } cfg_idx_e;

  // Control sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_ADD,
    S_DIVGO,
    S_DWAIT,
    S_MUL,
    S_SAT,
    S_OUT
  } state_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Duty limits in Q15.
  localparam logic signed [15:0] DUTY_MAX = 16'sd32767;
  localparam logic signed [15:0] DUTY_MIN = -16'sd32767;

  // Saturation limits of the current result.
  localparam logic signed [23:0] CUR_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] CUR_MIN = 24'sh800000;

  // Register values after reset.
  localparam logic [14:0] RST_RAMP_STEP   = 15'd3277;
  localparam logic        RST_INVERT_DIR  = 1'b0;
  localparam logic        RST_FAULT_SENSE = 1'b1;
  localparam logic        RST_ADC_PRESENT = 1'b1;
  localparam logic [7:0]  RST_ADC_PERIOD  = 8'd10;
  localparam logic [15:0] RST_CUR_GAIN    = 16'd1829;

  // Input item.
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] target_speed;
    logic               fault_n;
    logic signed [15:0] adc_code;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic signed [15:0] duty;
    logic [14:0]        pwm_ratio;
    logic               pwm_enable;
    logic               dir_a;
    logic               dir_b;
    logic signed [23:0] motor_current;
    logic signed [23:0] peak_current;
    logic               current_updated;
    logic               fault_seen;
  } out_item_t;

endpackage

[rtl/mdr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module mdr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the read data is registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/mdr_div.sv]
// Bit-serial signed-by-unsigned divider, truncating toward zero, one quotient bit per cycle.
module mdr_div #(
  parameter int unsigned DIVIDEND_W = 21,
  parameter int unsigned DIVISOR_W  = 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]         divisor_i,
  output logic                         done_o,
  output logic signed [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] acc_q, acc_d;
  logic [DIVISOR_W:0]    rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dsr_q, dsr_d;
  logic                  neg_q, neg_d;
  logic                  zero_q, zero_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W:0]    rem_sh;
  logic                  ge;
  logic [DIVISOR_W:0]    rem_nx;
  logic [DIVIDEND_W-1:0] acc_nx;

  // One restoring step: shift in the next dividend bit and try the subtraction.
  always_comb begin
    rem_sh = {rem_q[DIVISOR_W-1:0], acc_q[DIVIDEND_W-1]};
    ge     = (rem_sh >= {1'b0, dsr_q});
    rem_nx = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
    acc_nx = {acc_q[DIVIDEND_W-2:0], ge};
  end

  // Sequencing of the iterations and the final sign correction.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIVIDEND_W);
      acc_d  = dividend_i[DIVIDEND_W-1] ? (~dividend_i + 1'b1) : dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      neg_d  = dividend_i[DIVIDEND_W-1];
      zero_d = (divisor_i == '0);
    end else if (busy_q) begin
      acc_d = acc_nx;
      rem_d = rem_nx;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (zero_q) begin
          quo_d = '0;
        end else if (neg_q) begin
          quo_d = ~acc_nx + 1'b1;
        end else begin
          quo_d = acc_nx;
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
    quo_q  <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = $signed(quo_q);

endmodule

[rtl/motor_duty_ramp_current_sense_top.sv]
// Top level: duty ramp, direction and PWM outputs, offset store and current sensing.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_stall_o   in_data_i  (in_item_t)
//   out       output     out_valid_o / out_stall_i out_data_o (out_item_t)
//   cfg       input      cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// One item is in work at a time. Set-target, clear-peak and non-sampling ticks only
// execute and output; a calibration item reads and adds in the offset store in between.
// A sampling tick also runs the bit-serial mean divider, multiply and saturate steps,
// after a read and add when the sample enters the store. The store is a single RAM with
// registered read, read and written in separate cycles. Reset is asynchronous; the store
// needs no clearing. A finished result sits in the output register while the next item
// is taken in; that item then waits in its last step until the register is free.
module motor_duty_ramp_current_sense_top
  import mdr_pkg::*;
#(
  parameter int unsigned OFFSET_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned PTR_W        = $clog2(OFFSET_DEPTH);
  localparam int unsigned FILL_W       = $clog2(OFFSET_DEPTH + 1);
  localparam int unsigned OFFSET_SUM_W = $clog2(OFFSET_DEPTH) + 17;

  // Configuration registers.
  logic [14:0] ramp_step_q;
  logic        invert_dir_q;
  logic        fault_sense_q;
  logic        adc_present_q;
  logic [7:0]  adc_period_q;
  logic [15:0] cur_gain_q;

  // Sequencer and block state.
  state_e                    state_q, state_d;
  in_item_t                  item_q, item_d;
  logic signed [15:0]        duty_q, duty_d;
  logic signed [15:0]        target_q, target_d;
  logic [7:0]                countdown_q, countdown_d;
  logic [PTR_W-1:0]          ptr_q, ptr_d;
  logic [FILL_W-1:0]         fill_q, fill_d;
  logic signed [OFFSET_SUM_W-1:0] sum_q, sum_d;
  logic signed [23:0]        cur_q, cur_d;
  logic signed [23:0]        peak_q, peak_d;
  logic                      samp_q, samp_d;
  logic                      upd_q, upd_d;
  logic                      fault_q, fault_d;
  logic signed [16:0]        diff_q, diff_d;
  logic signed [33:0]        prod_q, prod_d;
  logic                      out_valid_q, out_valid_d;
  out_item_t                 out_q, out_d;

  // Combinational helpers.
  logic                      in_xfer;
  logic                      out_free;
  logic                      fault_now;
  logic signed [17:0]        duty_x;
  logic signed [17:0]        step_x;
  logic signed [17:0]        nd;
  logic signed [17:0]        dif;
  logic signed [17:0]        adif;
  logic signed [15:0]        ramp_duty;
  logic signed [15:0]        duty_eff;
  logic signed [15:0]        eff_mag;
  logic                      sample_now;
  logic                      add_now;
  logic signed [15:0]        tgt_clamped;
  logic signed [25:0]        shifted;
  logic signed [23:0]        sat;
  logic signed [15:0]        out_mag;
  logic                      out_neg;
  logic signed [OFFSET_SUM_W-1:0] old_x;

  // RAM and divider connections.
  logic                      ram_we;
  logic                      ram_re;
  logic [15:0]               ram_rdata;
  logic                      div_start;
  logic                      div_done;
  logic signed [OFFSET_SUM_W-1:0] div_quo;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_step_q   <= RST_RAMP_STEP;
      invert_dir_q  <= RST_INVERT_DIR;
      fault_sense_q <= RST_FAULT_SENSE;
      adc_present_q <= RST_ADC_PRESENT;
      adc_period_q  <= RST_ADC_PERIOD;
      cur_gain_q    <= RST_CUR_GAIN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RAMP_STEP:   ramp_step_q   <= cfg_data_i[14:0];
        CFG_INVERT_DIR:  invert_dir_q  <= cfg_data_i[0];
        CFG_FAULT_SENSE: fault_sense_q <= cfg_data_i[0];
        CFG_ADC_PRESENT: adc_present_q <= cfg_data_i[0];
        CFG_ADC_PERIOD:  adc_period_q  <= cfg_data_i[7:0];
        CFG_CUR_GAIN:    cur_gain_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Ramp of the present duty toward the target, snapping when the stepped duty lands within one step of it.
  always_comb begin
    fault_now = fault_sense_q && !item_q.fault_n;
    duty_x    = 18'(duty_q);
    step_x    = $signed({3'b000, ramp_step_q});
    nd        = (target_q > duty_q) ? (duty_x + step_x) : (duty_x - step_x);
    dif       = 18'(target_q) - nd;
    adif      = dif[17] ? -dif : dif;
    if (target_q == duty_q) begin
      ramp_duty = duty_q;
    end else if (adif < step_x) begin
      ramp_duty = target_q;
    end else begin
      ramp_duty = nd[15:0];
    end
    duty_eff   = fault_now ? duty_q : ramp_duty;
    eff_mag    = duty_eff[15] ? -duty_eff : duty_eff;
    sample_now = adc_present_q && (countdown_q == '0);
    add_now    = (eff_mag[14:0] < ramp_step_q);
  end

  // Target clamp, current scaling with saturation and result fields.
  always_comb begin
    tgt_clamped = (item_q.target_speed < DUTY_MIN) ? DUTY_MIN : item_q.target_speed;
    shifted     = prod_q[33:8];
    if ((shifted[25:23] == 3'b000) || (shifted[25:23] == 3'b111)) begin
      sat = shifted[23:0];
    end else begin
      sat = shifted[25] ? CUR_MIN : CUR_MAX;
    end
    out_neg = duty_q[15];
    out_mag = out_neg ? -duty_q : duty_q;
    old_x   = (fill_q == FILL_W'(OFFSET_DEPTH)) ? OFFSET_SUM_W'($signed(ram_rdata)) : '0;
  end

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        unique case (mode_e'(item_q.mode))
          MODE_TICK: begin
            if (sample_now) begin
              state_d = add_now ? S_READ : S_DIVGO;
            end else begin
              state_d = S_OUT;
            end
          end
          MODE_CAL: state_d = S_READ;
          MODE_SET: state_d = S_OUT;
          MODE_CLR: state_d = S_OUT;
          default:  state_d = S_OUT;
        endcase
      end
      S_READ:  state_d = S_ADD;
      S_ADD:   state_d = samp_q ? S_DIVGO : S_OUT;
      S_DIVGO: state_d = S_DWAIT;
      S_DWAIT: begin
        if (div_done) state_d = S_MUL;
      end
      S_MUL:   state_d = S_SAT;
      S_SAT:   state_d = S_OUT;
      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    ram_re     = (state_q == S_READ);
    ram_we     = (state_q == S_ADD);
    div_start  = (state_q == S_DIVGO);
  end

  // Datapath updates for each step of an item.
  always_comb begin
    item_d      = item_q;
    duty_d      = duty_q;
    target_d    = target_q;
    countdown_d = countdown_q;
    ptr_d       = ptr_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    cur_d       = cur_q;
    peak_d      = peak_q;
    samp_d      = samp_q;
    upd_d       = upd_q;
    fault_d     = fault_q;
    diff_d      = diff_q;
    prod_d      = prod_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (in_xfer) begin
      item_d = in_data_i;
    end
    unique case (state_q)
      S_EXEC: begin
        samp_d  = 1'b0;
        upd_d   = 1'b0;
        fault_d = 1'b0;
        unique case (mode_e'(item_q.mode))
          MODE_TICK: begin
            fault_d = fault_now;
            if (fault_now) begin
              target_d = '0;
            end else begin
              duty_d = ramp_duty;
            end
            if (adc_present_q) begin
              if (sample_now) begin
                samp_d      = 1'b1;
                upd_d       = 1'b1;
                countdown_d = adc_period_q;
              end else begin
                countdown_d = countdown_q - 1'b1;
              end
            end
          end
          MODE_CAL: ;
          MODE_SET: target_d = tgt_clamped;
          MODE_CLR: peak_d   = '0;
          default: ;
        endcase
      end
      S_ADD: begin
        // Replace the oldest entry once the ring is full.
        sum_d = sum_q - old_x + OFFSET_SUM_W'(item_q.adc_code);
        if (fill_q != FILL_W'(OFFSET_DEPTH)) begin
          fill_d = fill_q + 1'b1;
        end
        ptr_d = (ptr_q == PTR_W'(OFFSET_DEPTH - 1)) ? '0 : (ptr_q + 1'b1);
      end
      S_DWAIT: begin
        if (div_done) begin
          diff_d = 17'(item_q.adc_code) - 17'($signed(div_quo[15:0]));
        end
      end
      S_MUL: begin
        prod_d = diff_q * $signed({1'b0, cur_gain_q});
      end
      S_SAT: begin
        cur_d = sat;
        if (sat > peak_q) begin
          peak_d = sat;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.duty            = duty_q;
          out_d.pwm_ratio       = out_mag[14:0];
          out_d.pwm_enable      = (out_mag != '0);
          out_d.dir_a           = out_neg ^ invert_dir_q;
          out_d.dir_b           = ~(out_neg ^ invert_dir_q);
          out_d.motor_current   = cur_q;
          out_d.peak_current    = peak_q;
          out_d.current_updated = upd_q;
          out_d.fault_seen      = fault_q;
        end
      end
      default: ;
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      duty_q      <= '0;
      target_q    <= '0;
      countdown_q <= RST_ADC_PERIOD;
      ptr_q       <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      cur_q       <= '0;
      peak_q      <= '0;
      samp_q      <= 1'b0;
      upd_q       <= 1'b0;
      fault_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      duty_q      <= duty_d;
      target_q    <= target_d;
      countdown_q <= countdown_d;
      ptr_q       <= ptr_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      cur_q       <= cur_d;
      peak_q      <= peak_d;
      samp_q      <= samp_d;
      upd_q       <= upd_d;
      fault_q     <= fault_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    diff_q <= diff_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  // Offset store.
  mdr_ram #(
    .WIDTH(16),
    .DEPTH(OFFSET_DEPTH)
  ) u_offset_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (item_q.adc_code),
    .re_i    (ram_re),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  // Offset mean divider.
  mdr_div #(
    .DIVIDEND_W(OFFSET_SUM_W),
    .DIVISOR_W (FILL_W)
  ) u_mean_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (fill_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The fill count never runs past the ring depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(OFFSET_DEPTH))
    else $error("offset fill count exceeds the ring depth");

  // The write pointer stays inside the ring.
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PTR_W'(OFFSET_DEPTH - 1))
    else $error("offset pointer outside the ring");

  // The duty never reaches the most negative code.
  a_duty_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_q >= DUTY_MIN)
    else $error("duty outside its clamp range");

  // Leaving the result state always leaves a result in the output register.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free) |=> (out_valid_q && state_q == S_IDLE))
    else $error("result state left without loading the output register");

endmodule
